// ----- rtl/core/rbcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbcc_pkg
// Shared types and constants of the rotated box circle clamp: register
// indexes, field and stream widths, fraction bits, stage count, cosine reset.
// ----------------------------------------------------------------------------
package rbcc_pkg;

    // Widths of the payload fields.
    localparam int POS_W  = 32;
    localparam int RAD_W  = 31;
    localparam int TRIG_W = 16;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;

    // Packed stream widths, filled up to whole bytes.
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 64;

    // Fraction bits of the Q2.14 sine and cosine.
    localparam int Q14_SHIFT = 14;

    // Number of register stages in the datapath.
    localparam int N_STAGES = 7;

    // Reset value of the cosine register (1.0 in Q2.14).
    localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_HALF_WIDTH  = 3'd2,
        REG_HALF_HEIGHT = 3'd3,
        REG_SIN_ANGLE   = 3'd4,
        REG_COS_ANGLE   = 3'd5
    } t_cfg_idx;

endpackage

// ----- rtl/core/rotated_box_circle_clamp.sv -----
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while the output accepts; the seven
// register stages each hold one item and a stage whose successor is empty
// moves on even while the output stalls.
// Reset (synchronous, active low) empties all stages and sets the registers to
// centre 0, half sizes 0, sine 0 and cosine 1.0.
// ----------------------------------------------------------------------------
// rotated_box_circle_clamp
// Clamps a particle position so that its circle stays inside a rotated box:
// translate and rotate into the box frame, clamp each axis, rotate back,
// translate and saturate, as a seven stage pipeline.
// ----------------------------------------------------------------------------
module rotated_box_circle_clamp
    import rbcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Input stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: pos_x [31:0], pos_y [63:32], radius [94:64], zero [95]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // Output stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata: new_x [31:0], new_y [63:32]
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0]  r_center_x;
    logic signed [POS_W-1:0]  r_center_y;
    logic        [RAD_W-1:0]  r_half_width;
    logic        [RAD_W-1:0]  r_half_height;
    logic signed [TRIG_W-1:0] r_sin;
    logic signed [TRIG_W-1:0] r_cos;

    // A write to an index outside the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= '0;
            r_center_y    <= '0;
            r_half_width  <= '0;
            r_half_height <= '0;
            r_sin         <= '0;
            r_cos         <= COS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CENTER_X:    r_center_x    <= i_cfg_data;
                REG_CENTER_Y:    r_center_y    <= i_cfg_data;
                REG_HALF_WIDTH:  r_half_width  <= i_cfg_data[RAD_W-1:0];
                REG_HALF_HEIGHT: r_half_height <= i_cfg_data[RAD_W-1:0];
                REG_SIN_ANGLE:   r_sin         <= i_cfg_data[TRIG_W-1:0];
                REG_COS_ANGLE:   r_cos         <= i_cfg_data[TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage control: a stage loads when it is empty or its successor loads.
    // ------------------------------------------------------------------
    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] en;

    always_comb begin
        en[N_STAGES-1] = !r_vld[N_STAGES-1] || m_axis_tready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: offset from the box centre.
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0] in_x;
    logic signed [POS_W-1:0] in_y;
    logic        [RAD_W-1:0] in_r;
    logic signed [POS_W:0]   n1_dx;
    logic signed [POS_W:0]   n1_dy;
    logic signed [POS_W:0]   r1_dx;
    logic signed [POS_W:0]   r1_dy;
    logic        [RAD_W-1:0] r1_r;

    assign in_x  = s_axis_tdata[POS_W-1:0];
    assign in_y  = s_axis_tdata[2*POS_W-1:POS_W];
    assign in_r  = s_axis_tdata[2*POS_W+RAD_W-1:2*POS_W];
    assign n1_dx = (POS_W+1)'(in_x) - (POS_W+1)'(r_center_x);
    assign n1_dy = (POS_W+1)'(in_y) - (POS_W+1)'(r_center_y);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_dx <= n1_dx;
            r1_dy <= n1_dy;
            r1_r  <= in_r;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products of the forward rotation, and the clamp limits.
    // ------------------------------------------------------------------
    localparam int P1_W = POS_W + 1 + TRIG_W;

    logic signed [P1_W-1:0]  r2_xc;
    logic signed [P1_W-1:0]  r2_ys;
    logic signed [P1_W-1:0]  r2_yc;
    logic signed [P1_W-1:0]  r2_xs;
    logic signed [POS_W-1:0] n2_lox;
    logic signed [POS_W-1:0] n2_loy;
    logic signed [POS_W-1:0] r2_lox;
    logic signed [POS_W-1:0] r2_hix;
    logic signed [POS_W-1:0] r2_loy;
    logic signed [POS_W-1:0] r2_hiy;

    // radius - half size never leaves the 32-bit signed range.
    assign n2_lox = $signed({1'b0, r1_r}) - $signed({1'b0, r_half_width});
    assign n2_loy = $signed({1'b0, r1_r}) - $signed({1'b0, r_half_height});

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_xc  <= P1_W'(r1_dx) * P1_W'(r_cos);
            r2_ys  <= P1_W'(r1_dy) * P1_W'(r_sin);
            r2_yc  <= P1_W'(r1_dy) * P1_W'(r_cos);
            r2_xs  <= P1_W'(r1_dx) * P1_W'(r_sin);
            r2_lox <= n2_lox;
            r2_hix <= -n2_lox;
            r2_loy <= n2_loy;
            r2_hiy <= -n2_loy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum and round to Q16.16 (half rounds towards +infinity).
    // ------------------------------------------------------------------
    localparam int S1_W = P1_W + 1;
    localparam int U_W  = S1_W - Q14_SHIFT;

    logic signed [S1_W-1:0]  n3_su;
    logic signed [S1_W-1:0]  n3_sv;
    logic signed [U_W-1:0]   r3_u;
    logic signed [U_W-1:0]   r3_v;
    logic signed [POS_W-1:0] r3_lox;
    logic signed [POS_W-1:0] r3_hix;
    logic signed [POS_W-1:0] r3_loy;
    logic signed [POS_W-1:0] r3_hiy;

    assign n3_su = S1_W'(r2_xc) + S1_W'(r2_ys) + S1_W'(1 << (Q14_SHIFT - 1));
    assign n3_sv = S1_W'(r2_yc) - S1_W'(r2_xs) + S1_W'(1 << (Q14_SHIFT - 1));

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_u   <= n3_su[S1_W-1:Q14_SHIFT];
            r3_v   <= n3_sv[S1_W-1:Q14_SHIFT];
            r3_lox <= r2_lox;
            r3_hix <= r2_hix;
            r3_loy <= r2_loy;
            r3_hiy <= r2_hiy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: clamp each axis, lower limit first so the upper one wins.
    // ------------------------------------------------------------------
    logic signed [U_W-1:0]   n4_ua;
    logic signed [U_W-1:0]   n4_va;
    logic signed [U_W-1:0]   n4_ub;
    logic signed [U_W-1:0]   n4_vb;
    logic signed [POS_W-1:0] r4_u;
    logic signed [POS_W-1:0] r4_v;

    always_comb begin
        n4_ua = (r3_u < U_W'(r3_lox)) ? U_W'(r3_lox) : r3_u;
        n4_ub = (n4_ua > U_W'(r3_hix)) ? U_W'(r3_hix) : n4_ua;
        n4_va = (r3_v < U_W'(r3_loy)) ? U_W'(r3_loy) : r3_v;
        n4_vb = (n4_va > U_W'(r3_hiy)) ? U_W'(r3_hiy) : n4_va;
    end

    // The clamped value lies between two 32-bit limits, so it fits.
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_u <= n4_ub[POS_W-1:0];
            r4_v <= n4_vb[POS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: products of the backward rotation.
    // ------------------------------------------------------------------
    localparam int P2_W = POS_W + TRIG_W;

    logic signed [P2_W-1:0] r5_uc;
    logic signed [P2_W-1:0] r5_vs;
    logic signed [P2_W-1:0] r5_us;
    logic signed [P2_W-1:0] r5_vc;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r5_uc <= P2_W'(r4_u) * P2_W'(r_cos);
            r5_vs <= P2_W'(r4_v) * P2_W'(r_sin);
            r5_us <= P2_W'(r4_u) * P2_W'(r_sin);
            r5_vc <= P2_W'(r4_v) * P2_W'(r_cos);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: sum, round and add the centre back.
    // ------------------------------------------------------------------
    localparam int S2_W = P2_W + 1;
    localparam int R2_W = S2_W - Q14_SHIFT;
    localparam int N_W  = R2_W + 1;

    logic signed [S2_W-1:0] n6_sx;
    logic signed [S2_W-1:0] n6_sy;
    logic signed [R2_W-1:0] n6_rx;
    logic signed [R2_W-1:0] n6_ry;
    logic signed [N_W-1:0]  r6_nx;
    logic signed [N_W-1:0]  r6_ny;

    assign n6_sx = S2_W'(r5_uc) - S2_W'(r5_vs) + S2_W'(1 << (Q14_SHIFT - 1));
    assign n6_sy = S2_W'(r5_us) + S2_W'(r5_vc) + S2_W'(1 << (Q14_SHIFT - 1));
    assign n6_rx = n6_sx[S2_W-1:Q14_SHIFT];
    assign n6_ry = n6_sy[S2_W-1:Q14_SHIFT];

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r6_nx <= N_W'(n6_rx) + N_W'(r_center_x);
            r6_ny <= N_W'(n6_ry) + N_W'(r_center_y);
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: saturate to the 32-bit range into the output register.
    // ------------------------------------------------------------------
    localparam logic signed [N_W-1:0] SAT_MAX = N_W'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
    localparam logic signed [N_W-1:0] SAT_MIN = N_W'(-(64'sd1 <<< (POS_W - 1)));

    logic signed [POS_W-1:0] n7_x;
    logic signed [POS_W-1:0] n7_y;
    logic signed [POS_W-1:0] r7_x;
    logic signed [POS_W-1:0] r7_y;

    always_comb begin
        if (r6_nx > SAT_MAX) begin
            n7_x = SAT_MAX[POS_W-1:0];
        end else if (r6_nx < SAT_MIN) begin
            n7_x = SAT_MIN[POS_W-1:0];
        end else begin
            n7_x = r6_nx[POS_W-1:0];
        end
        if (r6_ny > SAT_MAX) begin
            n7_y = SAT_MAX[POS_W-1:0];
        end else if (r6_ny < SAT_MIN) begin
            n7_y = SAT_MIN[POS_W-1:0];
        end else begin
            n7_y = r6_ny[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r7_x <= n7_x;
            r7_y <= n7_y;
        end
    end

    assign m_axis_tvalid = r_vld[N_STAGES-1];
    assign m_axis_tdata  = {r7_y, r7_x};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Input is refused only when every stage holds an item.
    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&r_vld) |-> s_axis_tready)
        else $error("input refused while a stage is empty");

    // After the upper clamp the coordinate never exceeds its upper limit.
    a_clamp_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (n4_ub <= U_W'(r3_hix)) && (n4_vb <= U_W'(r3_hiy)))
        else $error("clamped coordinate above its upper limit");

    // Reset leaves no transaction pending at the output.
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rotated box circle clamp. Particles stream in
// over the input port while the box shape is changed between phases through
// the register port. Each accepted particle is run through a bit-exact model
// of the clamp kept in this file, and every output transaction is compared
// field by field with the oldest prediction. Both sides idle at random, the
// output side holds off once for a long stretch, and the sender drains the
// pipeline before every change of the box.
// ----------------------------------------------------------------------------
module tb;
    import rbcc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          RESET_CYCLES = 11;
    localparam int          N_PHASES = 14;
    localparam int          PHASE_ITEMS = 102;
    localparam int          HOLD_AT = 400;
    localparam int          HOLD_CYCLES = 120;

    // Indexes past the last register: writes there must have no effect.
    localparam logic [IDX_W-1:0] IDX_SPARE_6 = 3'd6;
    localparam logic [IDX_W-1:0] IDX_SPARE_7 = 3'd7;

    localparam longint ROUND_HALF = 64'sd8192;
    localparam longint INT32_HI = 64'sd2147483647;
    localparam longint INT32_LO = -64'sd2147483648;

    typedef struct {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [RAD_W-1:0]        radius;
    } t_particle;

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } t_point;

    typedef struct {
        logic signed [POS_W-1:0]  cx;
        logic signed [POS_W-1:0]  cy;
        logic [RAD_W-1:0]         hw;
        logic [RAD_W-1:0]         hh;
        logic signed [TRIG_W-1:0] sn;
        logic signed [TRIG_W-1:0] cs;
    } t_box;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [IDX_W-1:0]     i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    wire                  s_axis_tready;
    // tdata: pos_x [31:0], pos_y [63:32], radius [94:64], zero [95]
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    wire                  m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // tdata: new_x [31:0], new_y [63:32]
    wire  [M_TDATA_W-1:0] m_axis_tdata;

    // Box shape as the block currently holds it.
    t_box        box;
    t_particle   particle_q[$];
    t_point      clamped_q[$];

    int unsigned n_queued = 0;
    int unsigned n_in = 0;
    int unsigned n_results = 0;
    int unsigned n_errors = 0;
    int unsigned n_clamped = 0;
    int unsigned n_saturated = 0;
    int unsigned n_settings = 0;
    int unsigned n_stalled = 0;
    int unsigned n_cycles = 0;

    bit          tx_fire = 1'b0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    int unsigned rx_hold_left = 0;
    bit          rx_hold_done = 1'b0;

    rotated_box_circle_clamp u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock: 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Q.30 sum back to Q16.16, halves rounded towards plus infinity.
    function automatic longint round_q14(longint acc);
        return (acc + ROUND_HALF) >>> Q14_SHIFT;
    endfunction

    // Lower bound first, then the upper bound, so the upper one wins.
    function automatic longint clamp_to_slab(longint p, longint half, longint r);
        longint lo;
        longint hi;
        lo = r - half;
        hi = half - r;
        if (p < lo) p = lo;
        if (p > hi) p = hi;
        return p;
    endfunction

    function automatic logic signed [POS_W-1:0] saturate32(longint v);
        if (v > INT32_HI) return 32'sh7fff_ffff;
        if (v < INT32_LO) return 32'sh8000_0000;
        return v[POS_W-1:0];
    endfunction

    // Expected clamped position for one particle against the current box.
    function automatic t_point clamp_position(t_particle p);
        t_point res;
        longint c, s, dx, dy, u, v, uc, vc, nx, ny;
        c  = longint'(box.cs);
        s  = longint'(box.sn);
        dx = longint'(p.pos_x) - longint'(box.cx);
        dy = longint'(p.pos_y) - longint'(box.cy);
        u  = round_q14(dx * c + dy * s);
        v  = round_q14(dy * c - dx * s);
        uc = clamp_to_slab(u, longint'(box.hw), longint'(p.radius));
        vc = clamp_to_slab(v, longint'(box.hh), longint'(p.radius));
        if (uc != u || vc != v) n_clamped++;
        nx = round_q14(uc * c - vc * s) + longint'(box.cx);
        ny = round_q14(uc * s + vc * c) + longint'(box.cy);
        if (nx > INT32_HI || nx < INT32_LO || ny > INT32_HI || ny < INT32_LO)
            n_saturated++;
        res.x = saturate32(nx);
        res.y = saturate32(ny);
        return res;
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    task automatic note_failure(string msg);
        n_errors++;
        $error("%s", msg);
    endtask

    // Checks output transactions and predicts each accepted input transaction.
    always @(posedge i_clk) begin : scoreboard
        t_point    got;
        t_point    want;
        t_particle arrived;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.x = m_axis_tdata[31:0];
                got.y = m_axis_tdata[63:32];
                if (clamped_q.size() == 0) begin
                    note_failure($sformatf("unexpected result new_x %0d new_y %0d",
                                           got.x, got.y));
                end else begin
                    want = clamped_q.pop_front();
                    n_results++;
                    if (got.x !== want.x)
                        note_failure($sformatf("new_x: expected %0d, got %0d",
                                               want.x, got.x));
                    if (got.y !== want.y)
                        note_failure($sformatf("new_y: expected %0d, got %0d",
                                               want.y, got.y));
                end
            end
            if (s_axis_tvalid && !s_axis_tready) n_stalled++;
            if (s_axis_tvalid && s_axis_tready) begin
                arrived.pos_x  = s_axis_tdata[31:0];
                arrived.pos_y  = s_axis_tdata[63:32];
                arrived.radius = s_axis_tdata[94:64];
                clamped_q.push_back(clamp_position(arrived));
                n_in++;
                tx_fire = 1'b1;
            end
        end
    end

    // Driver: offers the next pending particle, with random gaps between.
    always @(negedge i_clk) begin : feeder
        t_particle nxt;
        if (!s_axis_tvalid || tx_fire) begin
            if (tx_gap != 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (particle_q.size() != 0) begin
                nxt = particle_q.pop_front();
                s_axis_tdata  <= {1'b0, nxt.radius, nxt.pos_y, nxt.pos_x};
                s_axis_tvalid <= 1'b1;
                tx_gap = tx_idle ? pick_gap() : 0;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        tx_fire = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off while input keeps coming.
    always @(negedge i_clk) begin
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!rx_hold_done && n_in >= HOLD_AT && particle_q.size() > 40) begin
            rx_hold_done = 1'b1;
            rx_hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rx_gap = rx_idle ? pick_gap() : 0;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     n_cycles, clamped_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_particle(logic [31:0] px, logic [31:0] py, logic [31:0] r);
        t_particle p;
        p.pos_x  = px;
        p.pos_y  = py;
        p.radius = r[RAD_W-1:0];
        particle_q.push_back(p);
        n_queued++;
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            REG_CENTER_X:    box.cx = value;
            REG_CENTER_Y:    box.cy = value;
            REG_HALF_WIDTH:  box.hw = value[RAD_W-1:0];
            REG_HALF_HEIGHT: box.hh = value[RAD_W-1:0];
            REG_SIN_ANGLE:   box.sn = value[TRIG_W-1:0];
            REG_COS_ANGLE:   box.cs = value[TRIG_W-1:0];
            default: ;
        endcase
    endtask

    // Reprogrammes the whole box; only called with the pipeline empty.
    task automatic set_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] hw,
                           logic [31:0] hh, logic [31:0] sn, logic [31:0] cs,
                           bit spare);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_HALF_WIDTH, hw);
        write_reg(REG_HALF_HEIGHT, hh);
        write_reg(REG_SIN_ANGLE, sn);
        write_reg(REG_COS_ANGLE, cs);
        if (spare) begin
            write_reg(IDX_SPARE_6, $urandom);
            write_reg(IDX_SPARE_7, $urandom);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Waits for every queued particle to be taken and every result to arrive.
    task automatic wait_for_drain();
        while (n_in != n_queued || clamped_q.size() != 0) @(posedge i_clk);
        repeat (N_STAGES + 3) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          phase, k;
        int unsigned span, kind;
        logic [31:0] cx, cy, hw, hh, sn, cs, r;
        longint      off, tmp_x, tmp_y;

        box.cx = '0;
        box.cy = '0;
        box.hw = '0;
        box.hh = '0;
        box.sn = '0;
        box.cs = COS_RESET;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset shape: a box of zero size, so every circle is at least as wide as it.
        queue_particle(32'h0, 32'h0, 32'h0);
        queue_particle(32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
        queue_particle(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        queue_particle(32'd12345, -32'sd678901, 32'h0001_0000);
        queue_particle(32'h8000_0000, 32'h7fff_ffff, 32'h1);
        wait_for_drain();

        // A box at 45 degrees: inside, beyond each side, circle wider than box.
        set_box(32'h0010_0000, -32'sh0020_0000, 32'h0008_0000, 32'h0004_0000,
                32'd11585, 32'd11585, 1'b0);
        queue_particle(32'h0010_0000, -32'sh0020_0000, 32'h0001_0000);
        queue_particle(32'h0050_0000, -32'sh0020_0000, 32'h0000_8000);
        queue_particle(-32'sh0030_0000, -32'sh0020_0000, 32'h0000_8000);
        queue_particle(32'h0010_0000, 32'h0020_0000, 32'h0000_4000);
        queue_particle(32'h0010_0000, -32'sh0060_0000, 32'h0);
        queue_particle(32'h0012_0000, -32'sh0021_0000, 32'h000a_0000);
        queue_particle(32'h0010_0000, -32'sh0020_0000, 32'h7fff_ffff);
        queue_particle(32'h8000_0000, 32'h7fff_ffff, 32'h0);
        wait_for_drain();

        // Trig values outside the unit range, centre at the extremes, values
        // too wide for their registers and writes to unused indexes.
        set_box(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000,
                32'h1234_7fff, 32'hffff_8000, 1'b1);
        queue_particle(32'h8000_0000, 32'h8000_0000, 32'h0);
        queue_particle(32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
        queue_particle(32'h0, 32'h0, 32'h7fff_ffff);
        queue_particle(32'h7fff_ffff, 32'h8000_0000, 32'h0001_2345);
        queue_particle(32'h8000_0000, 32'h7fff_ffff, 32'h0);
        queue_particle(32'h7fff_ffff, 32'h8000_0000, 32'h0);
        wait_for_drain();

        // Random phases, each with its own box shape and idling pattern.
        for (phase = 0; phase < N_PHASES; phase++) begin
            kind = (phase < 5) ? phase : $urandom_range(0, 4);
            cx = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            cy = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            hw = $urandom_range(0, 32'h0040_0000);
            hh = $urandom_range(0, 32'h0040_0000);
            sn = $urandom_range(0, 32768) - 16384;
            cs = $urandom_range(0, 32768) - 16384;
            case (kind)
                1: begin
                    // Axis-aligned, trig at plus or minus one.
                    if ($urandom_range(0, 1)) begin
                        sn = 32'd0;
                        cs = $urandom_range(0, 1) ? 32'd16384 : -32'sd16384;
                    end else begin
                        cs = 32'd0;
                        sn = $urandom_range(0, 1) ? 32'd16384 : -32'sd16384;
                    end
                end
                2: begin
                    // Largest or empty box anywhere in the plane.
                    cx = $urandom;
                    cy = $urandom;
                    hw = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h0;
                    hh = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h0;
                end
                3: begin
                    sn = $urandom;
                    cs = $urandom;
                end
                4: begin
                    hw = $urandom_range(0, 32'h0002_0000);
                    hh = $urandom_range(0, 32'h0002_0000);
                end
                default: ;
            endcase
            set_box(cx, cy, hw, hh, sn, cs, $urandom_range(0, 3) == 0);
            tx_idle = (phase % 4 == 0) || (phase % 4 == 2);
            rx_idle = (phase % 4 == 0) || (phase % 4 == 3);

            span = 32'((box.hw > box.hh) ? box.hw : box.hh);
            span = (span > 32'h2000_0000) ? 32'h4000_0000 : 2 * span + 32'h0004_0000;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 80) begin
                    // Near the box, at the scale of the box.
                    off   = longint'($urandom_range(0, 2 * span)) - longint'(span);
                    tmp_x = longint'(box.cx) + off;
                    off   = longint'($urandom_range(0, 2 * span)) - longint'(span);
                    tmp_y = longint'(box.cy) + off;
                    case ($urandom_range(0, 5))
                        0:       r = 32'h0;
                        1:       r = $urandom_range(0, span);
                        default: r = $urandom_range(0, span / 4);
                    endcase
                    queue_particle(tmp_x[31:0], tmp_y[31:0], r);
                end else begin
                    queue_particle($urandom, $urandom, $urandom);
                end
            end
            wait_for_drain();
        end

        $display("Clamped %0d particles over %0d box shapes: %0d moved, %0d saturated.",
                 n_results, n_settings, n_clamped, n_saturated);
        $display("Input held back for %0d cycles; %0d checks failed.",
                 n_stalled, n_errors);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
